// ===== design/tlf_pkg.sv =====
package tlf_pkg;

   // Line geometry.
   localparam int LINE_COLS = 32;
   localparam int TAB_STOP  = 8;
   localparam int CHAR_W    = 8;

   // A column count must hold LINE_COLS itself; an address only reaches LINE_COLS - 1.
   localparam int COL_W  = $clog2(LINE_COLS + 1);
   localparam int ADDR_W = $clog2(LINE_COLS);

   // Character codes that steer the folding.
   localparam logic [CHAR_W-1:0] CODE_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CODE_NL    = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_BLANK = 8'd32;

   // Command kinds passed from the front end to the back end.
   localparam logic [1:0] CMD_CHAR = 2'd0;
   localparam logic [1:0] CMD_TAB  = 2'd1;
   localparam logic [1:0] CMD_NL   = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [CHAR_W-1:0] ch;
   } cmd_type;

endpackage

// ===== design/text_line_folder_core.sv =====
// Text line folder. Each request beat carries one byte; the block keeps the current line in a
// 32-column line store and returns the folded text as response beats, with last_of_run set on
// the newline that closes each emitted line. A tab becomes blanks up to the next multiple of 8;
// a newline sends the buffered line (an empty line sends nothing); an ordinary byte that fills
// the line folds it just after the last blank past column 0, or at full width when there is
// none, and the remainder moves to the front. Text left in the store is never sent on its own.
// A front end classifies bytes into a two-entry command queue at one beat per cycle while
// the queue has a free entry. The back end runs one command at a time on the line store:
// an ordinary byte is written at the current column, a tab writes blanks one by one (up to 8),
// a line is sent beat by beat and then its newline, a fold search walks down from the last
// column, and the carry-over move copies each kept column to the front.
module text_line_folder_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [tlf_pkg::CHAR_W-1:0] req_in_char,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [tlf_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                       rsp_last_of_run
);

   logic             cmd_valid;
   tlf_pkg::cmd_type cmd;
   logic             cmd_pop;

   // Front end: classify bytes and queue them.
   tlf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_char (req_in_char),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   // Back end: line store sequencer and output register.
   tlf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== design/tlf_front.sv =====
module tlf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [tlf_pkg::CHAR_W-1:0] req_in_char,
   output logic                      cmd_valid,
   output tlf_pkg::cmd_type          cmd,
   input  logic                      cmd_pop
);

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   tlf_pkg::cmd_type     queue_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push;
   tlf_pkg::cmd_type     cls;

   // Classify the incoming byte into a command.
   always_comb begin
      cls.ch = req_in_char;
      if (req_in_char == tlf_pkg::CODE_TAB) begin
         cls.kind = tlf_pkg::CMD_TAB;
      end else if (req_in_char == tlf_pkg::CODE_NL) begin
         cls.kind = tlf_pkg::CMD_NL;
      end else begin
         cls.kind = tlf_pkg::CMD_CHAR;
      end
   end

   // Queue control: a beat is taken whenever there is a free entry.
   assign req_stall = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

   // The fill count never exceeds the queue depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("command queue overfilled");

   // The back end only pops a command that is present.
   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> count_ff != '0)
      else $error("pop from empty command queue");

   // A push without a pop grows the fill count by one.
   assert property (@(posedge clock) disable iff (reset)
      (push && !cmd_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("command queue count did not follow a push");

endmodule

// ===== design/tlf_back.sv =====
module tlf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  tlf_pkg::cmd_type           cmd,
   output logic                       cmd_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [tlf_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                       rsp_last_of_run
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_TAB    = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_EMIT   = 3'd3;
   localparam logic [2:0] S_SHIFT  = 3'd4;

   localparam int COL_W  = tlf_pkg::COL_W;
   localparam int ADDR_W = tlf_pkg::ADDR_W;
   localparam int CHAR_W = tlf_pkg::CHAR_W;

   logic [CHAR_W-1:0] line_store_ff [tlf_pkg::LINE_COLS];
   logic [CHAR_W-1:0] rd_data_ff;

   logic [2:0]        state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [COL_W-1:0]  idx_ff, idx_in;
   logic [COL_W-1:0]  cnt_ff, cnt_in;
   logic [COL_W-1:0]  fold_ff, fold_in;
   logic              shift_ff, shift_in;
   logic              data_ok_ff, data_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CHAR_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;

   logic              out_free;
   logic [COL_W-1:0]  tab_pos;
   logic [COL_W-1:0]  tab_next;
   logic              tab_full;
   logic              tab_end;
   logic [COL_W-1:0]  idx_inc;
   logic [COL_W-1:0]  idx_dec;
   logic [COL_W-1:0]  col_inc;

   // The output register can take a new beat when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Tab expansion: the blank written at tab_pos ends the tab at a stop or at line end.
   assign tab_pos  = (state_ff == S_TAB) ? idx_ff : col_ff;
   assign tab_next = tab_pos + 1'b1;
   assign tab_full = (tab_next == COL_W'(tlf_pkg::LINE_COLS));
   assign tab_end  = tab_full || ((tab_next % COL_W'(tlf_pkg::TAB_STOP)) == '0);

   assign idx_inc = idx_ff + 1'b1;
   assign idx_dec = idx_ff - 1'b1;
   assign col_inc = col_ff + 1'b1;

   // Sequencer: executes one command at a time over the line store.
   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      fold_in     = fold_ff;
      shift_in    = shift_ff;
      data_ok_in  = data_ok_ff;
      cmd_pop     = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = col_ff[ADDR_W-1:0];
      wr_data     = cmd.ch;
      rd_addr     = idx_ff[ADDR_W-1:0];
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  tlf_pkg::CMD_TAB: begin
                     wr_en   = 1'b1;
                     wr_data = tlf_pkg::CODE_BLANK;
                     if (!tab_end) begin
                        state_in = S_TAB;
                        idx_in   = tab_next;
                     end else if (tab_full) begin
                        state_in = S_EMIT;
                        idx_in   = '0;
                        cnt_in   = COL_W'(tlf_pkg::LINE_COLS);
                        shift_in = 1'b0;
                        rd_addr  = '0;
                     end else begin
                        col_in = tab_next;
                     end
                  end
                  tlf_pkg::CMD_NL: begin
                     // An empty line produces no output at all.
                     if (col_ff != '0) begin
                        state_in = S_EMIT;
                        idx_in   = '0;
                        cnt_in   = col_ff;
                        shift_in = 1'b0;
                        rd_addr  = '0;
                     end
                  end
                  default: begin
                     wr_en = 1'b1;
                     if (col_inc == COL_W'(tlf_pkg::LINE_COLS)) begin
                        state_in   = S_SEARCH;
                        idx_in     = COL_W'(tlf_pkg::LINE_COLS - 1);
                        data_ok_in = 1'b0;
                     end else begin
                        col_in = col_inc;
                     end
                  end
               endcase
            end
         end

         S_TAB: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[ADDR_W-1:0];
            wr_data = tlf_pkg::CODE_BLANK;
            if (!tab_end) begin
               idx_in = tab_next;
            end else if (tab_full) begin
               state_in = S_EMIT;
               idx_in   = '0;
               cnt_in   = COL_W'(tlf_pkg::LINE_COLS);
               shift_in = 1'b0;
               rd_addr  = '0;
            end else begin
               col_in   = tab_next;
               state_in = S_IDLE;
            end
         end

         S_SEARCH: begin
            // Walk down from the last column looking for a blank past column 0.
            if (!data_ok_ff) begin
               data_ok_in = 1'b1;
            end else if (idx_ff == '0) begin
               state_in = S_EMIT;
               idx_in   = '0;
               cnt_in   = COL_W'(tlf_pkg::LINE_COLS);
               shift_in = 1'b0;
               rd_addr  = '0;
            end else if (rd_data_ff == tlf_pkg::CODE_BLANK) begin
               state_in = S_EMIT;
               idx_in   = '0;
               cnt_in   = idx_inc;
               fold_in  = idx_inc;
               shift_in = (idx_inc != COL_W'(tlf_pkg::LINE_COLS));
               rd_addr  = '0;
            end else begin
               idx_in  = idx_dec;
               rd_addr = idx_dec[ADDR_W-1:0];
            end
         end

         S_EMIT: begin
            // Stream the stored text one beat a cycle while the output register is free, then the newline.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (idx_ff < cnt_ff) begin
                  rsp_char_in = rd_data_ff;
                  rsp_last_in = 1'b0;
                  idx_in      = idx_inc;
                  rd_addr     = idx_inc[ADDR_W-1:0];
               end else begin
                  rsp_char_in = tlf_pkg::CODE_NL;
                  rsp_last_in = 1'b1;
                  if (shift_ff) begin
                     state_in = S_SHIFT;
                     idx_in   = fold_ff;
                     rd_addr  = fold_ff[ADDR_W-1:0];
                  end else begin
                     state_in = S_IDLE;
                     col_in   = '0;
                  end
               end
            end
         end

         S_SHIFT: begin
            // Move the text after the fold point to the front of the line.
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(idx_ff - fold_ff);
            wr_data = rd_data_ff;
            if (idx_ff == COL_W'(tlf_pkg::LINE_COLS - 1)) begin
               state_in = S_IDLE;
               col_in   = COL_W'(tlf_pkg::LINE_COLS) - fold_ff;
            end else begin
               idx_in  = idx_inc;
               rd_addr = idx_inc[ADDR_W-1:0];
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Line store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= line_store_ff[rd_addr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         data_ok_ff   <= 1'b0;
         shift_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         data_ok_ff   <= data_ok_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Counters and the output beat.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      fold_ff     <= fold_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // The column always stays inside the line.
   assert property (@(posedge clock) disable iff (reset)
      col_ff < COL_W'(tlf_pkg::LINE_COLS))
      else $error("column ran past the line width");

   // Every run of output ends with a newline.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_char_ff == tlf_pkg::CODE_NL)
      else $error("final beat of a run is not a newline");

   // The emit counter never passes the line length being sent.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> idx_ff <= cnt_ff)
      else $error("emit index beyond line length");

   // A shift only follows a fold after a blank inside the line.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (fold_ff > COL_W'(1) &&
                                 fold_ff < COL_W'(tlf_pkg::LINE_COLS)))
      else $error("shift with an invalid fold point");

endmodule
